// File: hw/rtl/irp_pkg.sv
package irp_pkg;

   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 32;
   localparam int STEP_W   = 31;
   localparam int FACTOR_W = 16;
   localparam int FRAC_W   = 15;
   localparam int PROD_W   = STEP_W + FACTOR_W;
   localparam int CSR_AW   = 3;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd3;

   localparam logic [CSR_AW-1:0] CSR_INCREASE = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_DECREASE = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_STEP_MIN = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_STEP_MAX = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_INIT     = 3'd4;

   localparam logic [FACTOR_W-1:0] INCREASE_RESET = 16'd39322;
   localparam logic [FACTOR_W-1:0] DECREASE_RESET = 16'd16384;
   localparam logic [STEP_W-1:0]   STEP_MIN_RESET = 31'd1;
   localparam logic [STEP_W-1:0]   STEP_MAX_RESET = 31'd3276800;
   localparam logic [STEP_W-1:0]   INIT_RESET     = 31'd6554;

   typedef struct packed {
      logic [1:0]         sign;
      logic [STEP_W-1:0]  step;
      logic [VALUE_W-1:0] weight;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: hw/rtl/irp_ram.sv
module irp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/irprop_minus_weight_update_top.sv
// iRPROP- weight update engine.
// Input beats arrive on req_*: req_tuser selects load (0) or gradient
// update (1); req_tdata holds the weight index and the Q16.16 value.
// Each input beat yields exactly one result beat on rsp_* with the index,
// the new weight and the new step size of that entry.
// Weights, steps and last gradient signs live in one synchronous RAM of
// WEIGHT_COUNT entries. An item walks read, multiply, step clamp and
// weight write-back in the states ST_IDLE, ST_READ, ST_CALC and
// ST_FINISH; write-back also loads its result into the output register.
// The next item is accepted only once the state is back in ST_IDLE, so
// items do not overlap in the read-modify-write on the RAM.
// The output register holds a finished result while rsp_tready is low; the
// next item is still accepted and runs up to write-back, where it waits
// until the output register frees.
// Synchronous reset returns the control logic to idle and restores the
// csr registers; RAM contents are undefined until loaded.
// csr_* writes one register per cycle with csr_we; the user must write only while idle, the block does not enforce it.
module irprop_minus_weight_update_top
   import irp_pkg::*;
#(
   parameter int WEIGHT_COUNT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] weight_index, [41:10] item_value, [47:42] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [9:0] out_index, [41:10] new_weight, [72:42] new_step, [79:73] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [STEP_W-1:0]     csr_wdata
);

   localparam int AW  = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
   localparam int IXW = (AW > INDEX_W) ? AW : INDEX_W;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC, ST_FINISH} state_type;
   typedef enum logic [1:0] {ACT_LOAD, ACT_KEEP, ACT_GROW, ACT_SHRINK} action_type;

   state_type            state_ff, state_in;
   action_type           action_ff, action_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [FACTOR_W-1:0]  inc_ff, inc_in;
   logic [FACTOR_W-1:0]  dec_ff, dec_in;
   logic [STEP_W-1:0]    smin_ff, smin_in;
   logic [STEP_W-1:0]    smax_ff, smax_in;
   logic [STEP_W-1:0]    init_ff, init_in;

   logic                 kind_ff, kind_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic                 in_range_ff, in_range_in;
   logic [1:0]           cur_ff, cur_in;
   logic [VALUE_W-1:0]   weight_ff, weight_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   entry_type            rd_entry;
   entry_type            wr_entry;
   logic [ENTRY_W-1:0]   rd_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [IXW-1:0]       req_index_ext;
   logic [IXW-1:0]       index_ext;

   logic                 accept;
   logic [1:0]           val_sign;
   logic                 same_sign;
   logic                 opp_sign;
   logic [FACTOR_W-1:0]  factor;
   logic [VALUE_W-1:0]   scaled;
   logic [STEP_W-1:0]    scaled_sat;
   logic signed [VALUE_W:0] wsum;
   logic [VALUE_W-1:0]   wsat;
   logic                 out_free;

   irp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WEIGHT_COUNT),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready    = (state_ff == ST_IDLE);
   assign accept        = req_tvalid && req_tready;
   assign req_index_ext = IXW'(req_tdata[INDEX_W-1:0]);
   assign index_ext     = IXW'(index_ff);
   assign rd_addr       = req_index_ext[AW-1:0];
   assign wr_addr       = index_ext[AW-1:0];
   assign rd_en         = accept;
   assign rd_entry      = entry_type'(rd_data);
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

   assign val_sign  = value_ff[VALUE_W-1] ? SIGN_NEG :
                      ((value_ff != '0) ? SIGN_POS : SIGN_ZERO);
   assign same_sign = (val_sign != SIGN_ZERO) && (rd_entry.sign == val_sign);
   assign opp_sign  = (val_sign == SIGN_POS && rd_entry.sign == SIGN_NEG) ||
                      (val_sign == SIGN_NEG && rd_entry.sign == SIGN_POS);
   assign factor    = same_sign ? inc_ff : dec_ff;

   assign scaled     = prod_ff[PROD_W-1:FRAC_W];
   assign scaled_sat = scaled[VALUE_W-1] ? '1 : scaled[STEP_W-1:0];

   always_comb begin
      wsum = {weight_ff[VALUE_W-1], weight_ff};
      if (cur_ff == SIGN_POS) begin
         wsum = wsum - $signed({2'b00, step_ff});
      end else if (cur_ff == SIGN_NEG) begin
         wsum = wsum + $signed({2'b00, step_ff});
      end
      if (wsum[VALUE_W:VALUE_W-1] == 2'b01) begin
         wsat = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (wsum[VALUE_W:VALUE_W-1] == 2'b10) begin
         wsat = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         wsat = wsum[VALUE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      inc_in       = inc_ff;
      dec_in       = dec_ff;
      smin_in      = smin_ff;
      smax_in      = smax_ff;
      init_in      = init_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      in_range_in  = in_range_ff;
      cur_in       = cur_ff;
      weight_in    = weight_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      wr_en        = 1'b0;
      wr_entry     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_addr)
            CSR_INCREASE: inc_in  = csr_wdata[FACTOR_W-1:0];
            CSR_DECREASE: dec_in  = csr_wdata[FACTOR_W-1:0];
            CSR_STEP_MIN: smin_in = csr_wdata;
            CSR_STEP_MAX: smax_in = csr_wdata;
            CSR_INIT:     init_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in     = req_tuser;
               index_in    = req_tdata[INDEX_W-1:0];
               value_in    = req_tdata[INDEX_W+VALUE_W-1:INDEX_W];
               in_range_in = (32'(req_tdata[INDEX_W-1:0]) < WEIGHT_COUNT);
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            weight_in = rd_entry.weight;
            prod_in   = PROD_W'(rd_entry.step) * PROD_W'(factor);
            if (kind_ff == REQ_LOAD) begin
               action_in = ACT_LOAD;
               cur_in    = SIGN_ZERO;
            end else if (same_sign) begin
               action_in = ACT_GROW;
               cur_in    = val_sign;
            end else if (opp_sign) begin
               action_in = ACT_SHRINK;
               cur_in    = SIGN_ZERO;
            end else begin
               action_in = ACT_KEEP;
               cur_in    = val_sign;
            end
            step_in  = rd_entry.step;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            unique case (action_ff)
               ACT_LOAD:   step_in = init_ff;
               ACT_GROW:   step_in = (scaled_sat > smax_ff) ? smax_ff : scaled_sat;
               ACT_SHRINK: step_in = (scaled_sat < smin_ff) ? smin_ff : scaled_sat;
               default:    step_in = step_ff;
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               wr_entry.sign   = cur_ff;
               wr_entry.step   = step_ff;
               wr_entry.weight = (action_ff == ACT_LOAD) ? value_ff : wsat;
               wr_en           = in_range_ff;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = '0;
               rsp_data_in[INDEX_W-1:0] = index_ff;
               if (in_range_ff) begin
                  rsp_data_in[INDEX_W+VALUE_W-1:INDEX_W] = wr_entry.weight;
                  rsp_data_in[INDEX_W+VALUE_W+STEP_W-1:INDEX_W+VALUE_W] = step_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         action_ff    <= ACT_KEEP;
         rsp_valid_ff <= 1'b0;
         inc_ff       <= INCREASE_RESET;
         dec_ff       <= DECREASE_RESET;
         smin_ff      <= STEP_MIN_RESET;
         smax_ff      <= STEP_MAX_RESET;
         init_ff      <= INIT_RESET;
      end else begin
         state_ff     <= state_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
         inc_ff       <= inc_in;
         dec_ff       <= dec_in;
         smin_ff      <= smin_in;
         smax_ff      <= smax_in;
         init_ff      <= init_in;
      end
      rsp_data_ff <= rsp_data_in;
      kind_ff     <= kind_in;
      index_ff    <= index_in;
      value_ff    <= value_in;
      in_range_ff <= in_range_in;
      cur_ff      <= cur_in;
      weight_ff   <= weight_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
   end

endmodule
